[rtl/core/sit_pkg.sv]
// ----------------------------------------------------------------------------
// sit_pkg: shared types and constants for the sorted insert table
// Default sizes, operation and result kind codes, and the command struct
// that the top level hands to every cell of the chain.
// ----------------------------------------------------------------------------
package sit_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam int KEY_BITS_DEF    = 8;
    localparam int TAG_BITS_DEF    = 16;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DRAIN  = 1'b1;

    typedef enum logic [1:0] {
        KIND_ACCEPT = 2'd0,
        KIND_DROP   = 2'd1,
        KIND_ENTRY  = 2'd2,
        KIND_EMPTY  = 2'd3
    } kind_t;

    // Command broadcast to all cells in the same cycle
    typedef struct packed {
        logic insert;   // place the new entry, shift larger keys up
        logic shift;    // move every entry one cell toward the head
    } sit_cmd_t;

endpackage

[rtl/core/sit_cell.sv]
// ----------------------------------------------------------------------------
// sit_cell: one slot of the sorted insert chain
// Holds one (key, tag) entry. On insert it keeps, takes the new entry or
// takes its left neighbor; on shift it takes its right neighbor.
// ----------------------------------------------------------------------------
module sit_cell #(
    parameter int KEY_BITS = sit_pkg::KEY_BITS_DEF,
    parameter int TAG_BITS = sit_pkg::TAG_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  sit_pkg::sit_cmd_t   cmd,
    input  logic [KEY_BITS-1:0] ins_key,
    input  logic [TAG_BITS-1:0] ins_tag,
    input  logic                left_valid,
    input  logic                left_greater,
    input  logic [KEY_BITS-1:0] left_key,
    input  logic [TAG_BITS-1:0] left_tag,
    input  logic                right_valid,
    input  logic [KEY_BITS-1:0] right_key,
    input  logic [TAG_BITS-1:0] right_tag,
    output logic                valid,
    output logic                greater,
    output logic [KEY_BITS-1:0] key,
    output logic [TAG_BITS-1:0] tag
);
    import sit_pkg::*;

    logic                valid_reg, valid_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [TAG_BITS-1:0] tag_reg, tag_next;

    // Strictly greater keeps equal keys in arrival order
    assign greater = valid_reg && (key_reg > ins_key);

    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        tag_next   = tag_reg;
        if (cmd.insert)
        begin
            if (left_greater)
            begin
                valid_next = 1'b1;
                key_next   = left_key;
                tag_next   = left_tag;
            end
            else if (left_valid && (greater || !valid_reg))
            begin
                valid_next = 1'b1;
                key_next   = ins_key;
                tag_next   = ins_tag;
            end
        end
        else if (cmd.shift)
        begin
            valid_next = right_valid;
            key_next   = right_key;
            tag_next   = right_tag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        tag_reg <= tag_next;
    end

    assign valid = valid_reg;
    assign key   = key_reg;
    assign tag   = tag_reg;

endmodule

[rtl/core/stable_sorted_insert_table_unit.sv]
// ----------------------------------------------------------------------------
// stable_sorted_insert_table_unit: stable sorted (key, tag) table
// Chain of cells kept in ascending key order, with a registered result port.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on s_tvalid/s_tready. s_tuser is the operation (insert or
//   drain), s_tdata carries the key and tag. Results leave on m_tvalid/
//   m_tready with the kind on m_tuser, key and tag on m_tdata, and m_tlast
//   on the final result of each request.
//   Insert: one result (accepted, or dropped when every cell is full), in the
//   cycle after the request. A new insert is taken every cycle while the
//   result register drains; the insert itself lands in the chain at once,
//   since every cell decides from its own compare in parallel.
//   Drain: an empty table answers with one empty result in the next cycle.
//   Otherwise the chain shifts toward the head one cell per cycle while the
//   result register can take a value, and the head entry goes out with each
//   shift; no request is taken meanwhile. The table is empty afterwards.
//   Reset clears the cell valid bits, the drain flag and result valid bit.
//   While a result waits with m_tready low, it holds and s_tready drops, so
//   nothing is lost; the chain moves only when the result register is free.
// ----------------------------------------------------------------------------
module stable_sorted_insert_table_unit #(
    parameter int TABLE_DEPTH = sit_pkg::TABLE_DEPTH_DEF,
    parameter int KEY_BITS    = sit_pkg::KEY_BITS_DEF,
    parameter int TAG_BITS    = sit_pkg::TAG_BITS_DEF,
    localparam int DATA_W     = ((KEY_BITS + TAG_BITS + 7) / 8) * 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,   // sort_key, entry_tag
    input  logic              s_tuser,   // operation
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata,   // out_key, out_tag
    output logic [1:0]        m_tuser,   // kind
    output logic              m_tlast
);
    import sit_pkg::*;

    logic [KEY_BITS-1:0] in_key;
    logic [TAG_BITS-1:0] in_tag;

    logic [TABLE_DEPTH-1:0] valid_vec;
    logic [TABLE_DEPTH-1:0] gt_vec;
    logic [KEY_BITS-1:0]    key_arr [TABLE_DEPTH];
    logic [TAG_BITS-1:0]    tag_arr [TABLE_DEPTH];

    sit_cmd_t cmd;

    logic draining_reg, draining_next;
    logic out_valid_reg, out_valid_next;
    kind_t out_kind_reg, out_kind_next;
    logic [KEY_BITS-1:0] out_key_reg, out_key_next;
    logic [TAG_BITS-1:0] out_tag_reg, out_tag_next;
    logic out_last_reg, out_last_next;

    logic out_free;
    logic req_fire;
    logic full;

    assign in_key = s_tdata[KEY_BITS-1:0];
    assign in_tag = s_tdata[KEY_BITS +: TAG_BITS];

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = out_free && !draining_reg;
    assign req_fire = s_tvalid && s_tready;
    assign full     = valid_vec[TABLE_DEPTH-1];

    assign cmd.insert = req_fire && (s_tuser == OP_INSERT) && !full;
    assign cmd.shift  = draining_reg && out_free;

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_DEPTH; gi++)
        begin : g_cell
            logic                l_valid, l_greater, r_valid;
            logic [KEY_BITS-1:0] l_key, r_key;
            logic [TAG_BITS-1:0] l_tag, r_tag;

            if (gi == 0)
            begin : g_head
                assign l_valid   = 1'b1;
                assign l_greater = 1'b0;
                assign l_key     = '0;
                assign l_tag     = '0;
            end
            else
            begin : g_body
                assign l_valid   = valid_vec[gi-1];
                assign l_greater = gt_vec[gi-1];
                assign l_key     = key_arr[gi-1];
                assign l_tag     = tag_arr[gi-1];
            end

            if (gi == TABLE_DEPTH - 1)
            begin : g_tail
                assign r_valid = 1'b0;
                assign r_key   = '0;
                assign r_tag   = '0;
            end
            else
            begin : g_link
                assign r_valid = valid_vec[gi+1];
                assign r_key   = key_arr[gi+1];
                assign r_tag   = tag_arr[gi+1];
            end

            sit_cell #(
                .KEY_BITS (KEY_BITS),
                .TAG_BITS (TAG_BITS)
            ) u_cell (
                .clk          (clk),
                .rst_n        (rst_n),
                .cmd          (cmd),
                .ins_key      (in_key),
                .ins_tag      (in_tag),
                .left_valid   (l_valid),
                .left_greater (l_greater),
                .left_key     (l_key),
                .left_tag     (l_tag),
                .right_valid  (r_valid),
                .right_key    (r_key),
                .right_tag    (r_tag),
                .valid        (valid_vec[gi]),
                .greater      (gt_vec[gi]),
                .key          (key_arr[gi]),
                .tag          (tag_arr[gi])
            );
        end
    endgenerate

    always_comb
    begin
        draining_next  = draining_reg;
        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_key_next   = out_key_reg;
        out_tag_next   = out_tag_reg;
        out_last_next  = out_last_reg;
        if (out_free)
        begin
            out_valid_next = 1'b0;
            out_key_next   = '0;
            out_tag_next   = '0;
            out_last_next  = 1'b1;
            if (draining_reg)
            begin
                // emit the head cell; the chain shifts in the same edge
                out_valid_next = 1'b1;
                out_kind_next  = KIND_ENTRY;
                out_key_next   = key_arr[0];
                out_tag_next   = tag_arr[0];
                out_last_next  = !valid_vec[1];
                draining_next  = valid_vec[1];
            end
            else if (req_fire)
            begin
                if (s_tuser == OP_INSERT)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = full ? KIND_DROP : KIND_ACCEPT;
                end
                else if (!valid_vec[0])
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_EMPTY;
                end
                else
                begin
                    draining_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            draining_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            draining_reg  <= draining_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_kind_reg <= out_kind_next;
        out_key_reg  <= out_key_next;
        out_tag_reg  <= out_tag_next;
        out_last_reg <= out_last_next;
    end

    always_comb
    begin
        m_tdata                     = '0;
        m_tdata[KEY_BITS-1:0]       = out_key_reg;
        m_tdata[KEY_BITS +: TAG_BITS] = out_tag_reg;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

`ifndef ASSERT_OFF
    // Occupied cells always form a run starting at the head
    a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_vec & (valid_vec + 1'b1)) == '0)
        else $error("cell valid bits are not a contiguous prefix");

    // Status results always close their request
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != KIND_ENTRY) |-> m_tlast)
        else $error("status result without last");

    // A drain ends with the chain empty
    a_drain_clears: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(draining_reg) |-> !valid_vec[0])
        else $error("drain finished with entries left");

    // An insert into a full chain is reported as dropped
    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == OP_INSERT) && full
        |=> m_tvalid && (m_tuser == KIND_DROP) && full)
        else $error("insert into full table not dropped");
`endif

endmodule
